// File: design/afhbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anchor-free head box decode package
// Field widths, register indexes, reset values and decode limits shared by
// the box decoder and its checker.
// ----------------------------------------------------------------------------
package afhbd_pkg;

    localparam int LOGIT_W    = 16;
    localparam int GRID_W     = 10;
    localparam int DIST_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int AREA_CFG_W = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int POS_W      = 13;
    localparam int SIZE_W     = 14;

    localparam int MUL_A_W    = 20;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int FRAC_W     = 16;
    localparam int QUOT_W     = PROD_W - FRAC_W;
    localparam int AREA_W     = 2 * SIZE_W;

    localparam logic signed [LOGIT_W-1:0] LOGIT_MIN = 16'sh8000;
    localparam logic [GAIN_W-1:0]         GAIN_ONE  = 16'd256;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_LOGIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_LOGIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_LOGIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_AREA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_AREA  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PIXELS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_X_GAIN       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN       = 3'd7;

endpackage

// File: design/anchor_free_head_box_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anchor-free head box decode
// Tracks the largest class logit of a grid cell and, on the closing word,
// forms the box from the edge distances with one shared multiplier, then
// applies the score, tier and minimum-area tests.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_stall   kind, class_logit, grid, dists
//  out      source     o_out_valid / i_out_stall box_x/y/w/h, score_logit
//  cfg      sink       i_cfg_we                  i_cfg_index, i_cfg_data
//
// A logit word is taken every cycle while no close word is in progress. A close
// word holds the input while five products (x, y, w, h, area) each pass through
// a multiply state and a scaling state of the single multiplier, followed by a
// decide state. A kept box waits in the decide state while a previous box is stalled.
// Reset is synchronous and active low and returns the running maximum to the
// lowest logit.
// ----------------------------------------------------------------------------
module anchor_free_head_box_decode (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic                                      i_kind,
    input  logic signed [afhbd_pkg::LOGIT_W-1:0]      i_class_logit,
    input  logic        [afhbd_pkg::GRID_W-1:0]       i_grid_col,
    input  logic        [afhbd_pkg::GRID_W-1:0]       i_grid_row,
    input  logic signed [afhbd_pkg::DIST_W-1:0]       i_dist_left,
    input  logic signed [afhbd_pkg::DIST_W-1:0]       i_dist_top,
    input  logic signed [afhbd_pkg::DIST_W-1:0]       i_dist_right,
    input  logic signed [afhbd_pkg::DIST_W-1:0]       i_dist_bottom,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [afhbd_pkg::POS_W-1:0]        o_box_x,
    output logic signed [afhbd_pkg::POS_W-1:0]        o_box_y,
    output logic signed [afhbd_pkg::SIZE_W-1:0]       o_box_w,
    output logic signed [afhbd_pkg::SIZE_W-1:0]       o_box_h,
    output logic signed [afhbd_pkg::LOGIT_W-1:0]      o_score_logit,
    input  logic                                      i_cfg_we,
    input  logic        [afhbd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic        [afhbd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_POST, S_DECIDE} t_state;
    typedef enum logic [2:0] {STEP_X, STEP_Y, STEP_W, STEP_H, STEP_AREA} t_step;

    localparam int LW = afhbd_pkg::LOGIT_W;
    localparam int DW = afhbd_pkg::DIST_W;
    localparam int GW = afhbd_pkg::GRID_W;
    localparam int AW = afhbd_pkg::MUL_A_W;
    localparam int BW = afhbd_pkg::MUL_B_W;
    localparam int PW = afhbd_pkg::PROD_W;
    localparam int QW = afhbd_pkg::QUOT_W;
    localparam int XW = afhbd_pkg::POS_W;
    localparam int SW = afhbd_pkg::SIZE_W;
    localparam int RW = afhbd_pkg::AREA_W;
    localparam int CW = afhbd_pkg::AREA_CFG_W;
    localparam int GNW = afhbd_pkg::GAIN_W;

    t_state r_state;
    t_step  r_step;

    logic signed [LW-1:0] r_base_logit, r_small_logit, r_medium_logit;
    logic        [CW-1:0] r_small_area, r_medium_area, r_min_pixels;
    logic        [GNW-1:0] r_x_gain, r_y_gain;

    logic signed [LW-1:0] r_max;
    logic signed [LW-1:0] r_score;
    logic        [GW-1:0] r_col, r_row;
    logic signed [DW-1:0] r_dl, r_dt, r_dr, r_db;
    logic signed [PW-1:0] r_prod;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [SW-1:0] r_w, r_h;
    logic signed [RW-1:0] r_area;

    logic                 r_out_valid;
    logic signed [XW-1:0] r_box_x, r_box_y;
    logic signed [SW-1:0] r_box_w, r_box_h;
    logic signed [LW-1:0] r_box_score;

    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] prod_adj;
    logic signed [QW-1:0] quot;
    logic signed [XW-1:0] quot_pos;
    logic signed [SW-1:0] quot_size;
    logic signed [RW:0]   area_ext;
    logic                 below_small, below_medium, below_min;
    logic signed [LW-1:0] tier;
    logic                 keep;

    always_comb begin
        case (r_step)
            STEP_X: begin
                mul_a = $signed({2'b00, r_col, 8'h00}) - AW'(r_dl);
                mul_b = $signed({1'b0, r_x_gain});
            end
            STEP_Y: begin
                mul_a = $signed({2'b00, r_row, 8'h00}) - AW'(r_dt);
                mul_b = $signed({1'b0, r_y_gain});
            end
            STEP_W: begin
                mul_a = AW'(r_dl) + AW'(r_dr);
                mul_b = $signed({1'b0, r_x_gain});
            end
            STEP_H: begin
                mul_a = AW'(r_dt) + AW'(r_db);
                mul_b = $signed({1'b0, r_y_gain});
            end
            STEP_AREA: begin
                mul_a = AW'(r_w);
                mul_b = BW'(r_h);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Division by 65536 truncates toward zero, so negative products are biased.
    assign prod_adj = r_prod + (r_prod[PW-1] ? PW'(65535) : PW'(0));
    assign quot     = prod_adj[PW-1:afhbd_pkg::FRAC_W];

    always_comb begin
        if (quot > QW'(4095)) begin
            quot_pos = XW'(4095);
        end else if (quot < -QW'(4096)) begin
            quot_pos = -XW'(4096);
        end else begin
            quot_pos = quot[XW-1:0];
        end
        if (quot > QW'(8191)) begin
            quot_size = SW'(8191);
        end else if (quot < -QW'(8192)) begin
            quot_size = -SW'(8192);
        end else begin
            quot_size = quot[SW-1:0];
        end
    end

    assign area_ext     = {r_area[RW-1], r_area};
    assign below_small  = area_ext < $signed({{(RW+1-CW){1'b0}}, r_small_area});
    assign below_medium = area_ext < $signed({{(RW+1-CW){1'b0}}, r_medium_area});
    assign below_min    = area_ext < $signed({{(RW+1-CW){1'b0}}, r_min_pixels});

    always_comb begin
        if (below_small) begin
            tier = r_small_logit;
        end else if (below_medium) begin
            tier = r_medium_logit;
        end else begin
            tier = r_base_logit;
        end
    end

    assign keep = (r_score > r_base_logit) && !(r_score < tier) && !below_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_step         <= STEP_X;
            r_max          <= afhbd_pkg::LOGIT_MIN;
            r_out_valid    <= 1'b0;
            r_base_logit   <= '0;
            r_small_logit  <= '0;
            r_medium_logit <= '0;
            r_small_area   <= '0;
            r_medium_area  <= '0;
            r_min_pixels   <= '0;
            r_x_gain       <= afhbd_pkg::GAIN_ONE;
            r_y_gain       <= afhbd_pkg::GAIN_ONE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    afhbd_pkg::REG_BASE_LOGIT:   r_base_logit   <= i_cfg_data[LW-1:0];
                    afhbd_pkg::REG_SMALL_LOGIT:  r_small_logit  <= i_cfg_data[LW-1:0];
                    afhbd_pkg::REG_MEDIUM_LOGIT: r_medium_logit <= i_cfg_data[LW-1:0];
                    afhbd_pkg::REG_SMALL_AREA:   r_small_area   <= i_cfg_data[CW-1:0];
                    afhbd_pkg::REG_MEDIUM_AREA:  r_medium_area  <= i_cfg_data[CW-1:0];
                    afhbd_pkg::REG_MIN_PIXELS:   r_min_pixels   <= i_cfg_data[CW-1:0];
                    afhbd_pkg::REG_X_GAIN:       r_x_gain       <= i_cfg_data[GNW-1:0];
                    afhbd_pkg::REG_Y_GAIN:       r_y_gain       <= i_cfg_data[GNW-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && !(r_state == S_DECIDE && keep)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (!i_kind) begin
                            if (i_class_logit > r_max) begin
                                r_max <= i_class_logit;
                            end
                        end else begin
                            r_score <= r_max;
                            r_max   <= afhbd_pkg::LOGIT_MIN;
                            r_col   <= i_grid_col;
                            r_row   <= i_grid_row;
                            r_dl    <= i_dist_left;
                            r_dt    <= i_dist_top;
                            r_dr    <= i_dist_right;
                            r_db    <= i_dist_bottom;
                            r_step  <= STEP_X;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_POST;
                end
                S_POST: begin
                    case (r_step)
                        STEP_X: begin
                            r_x     <= quot_pos;
                            r_step  <= STEP_Y;
                            r_state <= S_MUL;
                        end
                        STEP_Y: begin
                            r_y     <= quot_pos;
                            r_step  <= STEP_W;
                            r_state <= S_MUL;
                        end
                        STEP_W: begin
                            r_w     <= quot_size;
                            r_step  <= STEP_H;
                            r_state <= S_MUL;
                        end
                        STEP_H: begin
                            r_h     <= quot_size;
                            r_step  <= STEP_AREA;
                            r_state <= S_MUL;
                        end
                        default: begin
                            r_area  <= r_prod[RW-1:0];
                            r_state <= S_DECIDE;
                        end
                    endcase
                end
                S_DECIDE: begin
                    if (!keep) begin
                        r_state <= S_IDLE;
                    end else if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_box_x     <= r_x;
                        r_box_y     <= r_y;
                        r_box_w     <= r_w;
                        r_box_h     <= r_h;
                        r_box_score <= r_score;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_box_x       = r_box_x;
    assign o_box_y       = r_box_y;
    assign o_box_w       = r_box_w;
    assign o_box_h       = r_box_h;
    assign o_score_logit = r_box_score;

endmodule

// File: design/afhbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anchor-free head box decode checker
// Port-level properties of the box decoder, attached to the top level.
// ----------------------------------------------------------------------------
module afhbd_checker (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    input  logic                                      o_in_stall,
    input  logic                                      i_kind,
    input  logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    input  logic signed [afhbd_pkg::POS_W-1:0]        o_box_x,
    input  logic signed [afhbd_pkg::LOGIT_W-1:0]      o_score_logit
);

    // A close word starts the multiply sequence, so the input is held next.
    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_kind |=> o_in_stall)
        else $error("input not held after a close word");

    // Logit words never occupy the sequencer.
    a_logit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_kind |=> !o_in_stall)
        else $error("input held after a logit word");

    // A new box only follows a busy sequence.
    a_out_from_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("box word appeared without a close sequence");

    // A kept score beats the base threshold, so it is never the lowest logit.
    a_score_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_score_logit != afhbd_pkg::LOGIT_MIN)
        else $error("box word carries the empty-cell score");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_box_x))
        else $error("stalled box word changed");

endmodule

bind anchor_free_head_box_decode afhbd_checker u_afhbd_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box decode scoreboard bench
// Streams cells of class-logit words, each closed by a geometry word, into the
// box decoder under bursty input and patterned output stall. A local model
// tracks the cell maximum and predicts each kept box, which is checked field
// by field against the decoder output. Thresholds, area bounds and gains are
// reprogrammed between phases while the decoder is idle.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LOGIT_W    = afhbd_pkg::LOGIT_W;
    localparam int GRID_W     = afhbd_pkg::GRID_W;
    localparam int DIST_W     = afhbd_pkg::DIST_W;
    localparam int GAIN_W     = afhbd_pkg::GAIN_W;
    localparam int AREA_CFG_W = afhbd_pkg::AREA_CFG_W;
    localparam int CFG_DATA_W = afhbd_pkg::CFG_DATA_W;
    localparam int CFG_IDX_W  = afhbd_pkg::CFG_IDX_W;
    localparam int POS_W      = afhbd_pkg::POS_W;
    localparam int SIZE_W     = afhbd_pkg::SIZE_W;

    localparam logic KIND_LOGIT = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;
    localparam int   SETTLE_CYCLES = 24;

    typedef struct {
        logic                      kind;
        logic signed [LOGIT_W-1:0] logit;
        logic [GRID_W-1:0]         col;
        logic [GRID_W-1:0]         row;
        logic signed [DIST_W-1:0]  dl;
        logic signed [DIST_W-1:0]  dt;
        logic signed [DIST_W-1:0]  dr;
        logic signed [DIST_W-1:0]  db;
    } t_cell_word;

    typedef struct {
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [SIZE_W-1:0]  w;
        logic signed [SIZE_W-1:0]  h;
        logic signed [LOGIT_W-1:0] score;
    } t_box;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      kind = KIND_LOGIT;
    logic signed [LOGIT_W-1:0] class_logit = '0;
    logic [GRID_W-1:0]         grid_col = '0;
    logic [GRID_W-1:0]         grid_row = '0;
    logic signed [DIST_W-1:0]  dist_left = '0;
    logic signed [DIST_W-1:0]  dist_top = '0;
    logic signed [DIST_W-1:0]  dist_right = '0;
    logic signed [DIST_W-1:0]  dist_bottom = '0;

    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [POS_W-1:0]   box_x;
    logic signed [POS_W-1:0]   box_y;
    logic signed [SIZE_W-1:0]  box_w;
    logic signed [SIZE_W-1:0]  box_h;
    logic signed [LOGIT_W-1:0] score_logit;

    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    anchor_free_head_box_decode dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_kind        (kind),
        .i_class_logit (class_logit),
        .i_grid_col    (grid_col),
        .i_grid_row    (grid_row),
        .i_dist_left   (dist_left),
        .i_dist_top    (dist_top),
        .i_dist_right  (dist_right),
        .i_dist_bottom (dist_bottom),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_box_x       (box_x),
        .o_box_y       (box_y),
        .o_box_w       (box_w),
        .o_box_h       (box_h),
        .o_score_logit (score_logit),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // Local copy of the decoder registers and the running cell maximum.
    logic signed [LOGIT_W-1:0] base_thr = '0;
    logic signed [LOGIT_W-1:0] small_thr = '0;
    logic signed [LOGIT_W-1:0] medium_thr = '0;
    logic [AREA_CFG_W-1:0]     small_area = '0;
    logic [AREA_CFG_W-1:0]     medium_area = '0;
    logic [AREA_CFG_W-1:0]     min_pixels = '0;
    logic [GAIN_W-1:0]         x_gain = afhbd_pkg::GAIN_ONE;
    logic [GAIN_W-1:0]         y_gain = afhbd_pkg::GAIN_ONE;
    logic signed [LOGIT_W-1:0] cell_max = afhbd_pkg::LOGIT_MIN;

    t_cell_word cell_words_pending[$];
    t_box       boxes_due[$];
    t_cell_word word_on_bus;
    int         words_queued = 0;
    int         box_mismatches = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    bit         sender_hold = 1'b0;
    t_stall_mode stall_mode = STALL_NONE;
    int         stall_timer = 0;
    int         stall_phase = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void decode_cell_word(input t_cell_word word);
        logic signed [LOGIT_W-1:0] score;
        logic signed [LOGIT_W-1:0] tier;
        longint bx, by, bw, bh, area;
        bit keep;
        t_box box;
        if (word.kind == KIND_LOGIT) begin
            if (word.logit > cell_max) cell_max = word.logit;
            return;
        end
        score = cell_max;
        cell_max = afhbd_pkg::LOGIT_MIN;
        bx = clamp(((longint'(word.col) * 256 - longint'(word.dl)) * longint'(x_gain)) / 65536,
                   -4096, 4095);
        by = clamp(((longint'(word.row) * 256 - longint'(word.dt)) * longint'(y_gain)) / 65536,
                   -4096, 4095);
        bw = clamp(((longint'(word.dl) + longint'(word.dr)) * longint'(x_gain)) / 65536,
                   -8192, 8191);
        bh = clamp(((longint'(word.dt) + longint'(word.db)) * longint'(y_gain)) / 65536,
                   -8192, 8191);
        area = bw * bh;
        keep = score > base_thr;
        if (keep) begin
            tier = base_thr;
            if (area < longint'(small_area)) tier = small_thr;
            else if (area < longint'(medium_area)) tier = medium_thr;
            if (score < tier) keep = 1'b0;
            if (area < longint'(min_pixels)) keep = 1'b0;
        end
        if (keep) begin
            box.x = POS_W'(bx);
            box.y = POS_W'(by);
            box.w = SIZE_W'(bw);
            box.h = SIZE_W'(bh);
            box.score = score;
            boxes_due.insert(boxes_due.size(), box);
        end
    endfunction

    // Input side: words leave the pending queue in bursts separated by gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) decode_cell_word(word_on_bus);
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (!sender_hold && cell_words_pending.size() > 0) begin
                    word_on_bus = cell_words_pending.pop_front();
                    kind        <= word_on_bus.kind;
                    class_logit <= word_on_bus.logit;
                    grid_col    <= word_on_bus.col;
                    grid_row    <= word_on_bus.row;
                    dist_left   <= word_on_bus.dl;
                    dist_top    <= word_on_bus.dt;
                    dist_right  <= word_on_bus.dr;
                    dist_bottom <= word_on_bus.db;
                    in_valid    <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        burst_left = $urandom_range(1, 40);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each accepted box and stall on a changing pattern.
    always @(posedge i_clk) begin
        t_box expected;
        logic stall_next;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (boxes_due.size() == 0) begin
                    box_mismatches++;
                    if (box_mismatches <= 10)
                        $display("unexpected box: x=%0d y=%0d w=%0d h=%0d score=%0d",
                                 box_x, box_y, box_w, box_h, score_logit);
                end else begin
                    expected = boxes_due.pop_front();
                    if (box_x !== expected.x || box_y !== expected.y || box_w !== expected.w ||
                        box_h !== expected.h || score_logit !== expected.score) begin
                        box_mismatches++;
                        if (box_mismatches <= 10) begin
                            $write("box mismatch: expected x=%0d y=%0d w=%0d h=%0d score=%0d, ",
                                   expected.x, expected.y, expected.w, expected.h,
                                   expected.score);
                            $display("got x=%0d y=%0d w=%0d h=%0d score=%0d",
                                     box_x, box_y, box_w, box_h, score_logit);
                        end
                    end
                end
            end
            if (stall_timer == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_timer = $urandom_range(20, 150);
            end else begin
                stall_timer--;
            end
            stall_phase = (stall_phase + 1) % 7;
            case (stall_mode)
                STALL_NONE:  stall_next = 1'b0;
                STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
                STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
                default:     stall_next = (stall_phase < 3);
            endcase
            out_stall <= stall_next;
        end
    end

    function automatic void push_logit(input logic signed [LOGIT_W-1:0] v);
        t_cell_word word;
        word.kind = KIND_LOGIT;
        word.logit = v;
        word.col = GRID_W'($urandom);
        word.row = GRID_W'($urandom);
        word.dl = DIST_W'($urandom);
        word.dt = DIST_W'($urandom);
        word.dr = DIST_W'($urandom);
        word.db = DIST_W'($urandom);
        cell_words_pending.insert(cell_words_pending.size(), word);
        words_queued++;
    endfunction

    function automatic void push_close(input logic [GRID_W-1:0] col, input logic [GRID_W-1:0] row,
                                       input logic signed [DIST_W-1:0] dl,
                                       input logic signed [DIST_W-1:0] dt,
                                       input logic signed [DIST_W-1:0] dr,
                                       input logic signed [DIST_W-1:0] db);
        t_cell_word word;
        word.kind = KIND_CLOSE;
        word.logit = LOGIT_W'($urandom);
        word.col = col;
        word.row = row;
        word.dl = dl;
        word.dt = dt;
        word.dr = dr;
        word.db = db;
        cell_words_pending.insert(cell_words_pending.size(), word);
        words_queued++;
    endfunction

    function automatic void push_random_cell(input bit wild);
        int n;
        logic signed [DIST_W-1:0] d[4];
        n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
        repeat (n) begin
            if (wild || $urandom_range(0, 4) == 0)
                push_logit(LOGIT_W'($urandom));
            else
                push_logit(LOGIT_W'(int'($urandom_range(0, 2048)) - 1024));
        end
        foreach (d[i]) begin
            if (wild || $urandom_range(0, 5) == 0)
                d[i] = DIST_W'($urandom);
            else
                d[i] = DIST_W'(int'($urandom_range(0, 4352)) - 256);
        end
        push_close(GRID_W'($urandom), GRID_W'($urandom), d[0], d[1], d[2], d[3]);
    endfunction

    function automatic logic [7:0] junk_bits();
        return ($urandom_range(0, 1) == 1) ? 8'($urandom) : 8'd0;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            afhbd_pkg::REG_BASE_LOGIT:   base_thr = data[LOGIT_W-1:0];
            afhbd_pkg::REG_SMALL_LOGIT:  small_thr = data[LOGIT_W-1:0];
            afhbd_pkg::REG_MEDIUM_LOGIT: medium_thr = data[LOGIT_W-1:0];
            afhbd_pkg::REG_SMALL_AREA:   small_area = data[AREA_CFG_W-1:0];
            afhbd_pkg::REG_MEDIUM_AREA:  medium_area = data[AREA_CFG_W-1:0];
            afhbd_pkg::REG_MIN_PIXELS:   min_pixels = data[AREA_CFG_W-1:0];
            afhbd_pkg::REG_X_GAIN:       x_gain = data[GAIN_W-1:0];
            afhbd_pkg::REG_Y_GAIN:       y_gain = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // The upper bits of the 16-bit registers are sometimes filled with noise.
    task automatic program_regs(input logic [15:0] base, input logic [15:0] small_t,
                                input logic [15:0] medium_t, input logic [23:0] sarea,
                                input logic [23:0] marea, input logic [23:0] minpix,
                                input logic [15:0] xg, input logic [15:0] yg);
        write_reg(afhbd_pkg::REG_BASE_LOGIT, {junk_bits(), base});
        write_reg(afhbd_pkg::REG_SMALL_LOGIT, {junk_bits(), small_t});
        write_reg(afhbd_pkg::REG_MEDIUM_LOGIT, {junk_bits(), medium_t});
        write_reg(afhbd_pkg::REG_SMALL_AREA, sarea);
        write_reg(afhbd_pkg::REG_MEDIUM_AREA, marea);
        write_reg(afhbd_pkg::REG_MIN_PIXELS, minpix);
        write_reg(afhbd_pkg::REG_X_GAIN, {junk_bits(), xg});
        write_reg(afhbd_pkg::REG_Y_GAIN, {junk_bits(), yg});
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (cell_words_pending.size() != 0 || in_valid || boxes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int phase_start;
        int base;
        int sarea;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: empty cell, lowest logit, extreme geometry, negative sizes.
        push_close(10'd0, 10'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        push_logit(afhbd_pkg::LOGIT_MIN);
        push_close(10'd5, 10'd7, 16'sd256, 16'sd256, 16'sd256, 16'sd256);
        push_logit(16'sh7FFF);
        push_logit(-16'sd1);
        push_close(10'd1023, 10'd1023, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        push_logit(16'sd1);
        push_logit(16'sd0);
        push_close(10'd0, 10'd0, 16'sh8000, 16'sd256, 16'sh8000, 16'sd256);
        push_logit(16'sd0);
        push_close(10'd3, 10'd3, 16'sd512, 16'sd512, 16'sd512, 16'sd512);
        push_logit(16'sd5);
        push_close(10'd2, 10'd2, -16'sd256, -16'sd256, -16'sd256, -16'sd256);
        wait_idle();

        // Full gains and the widest bounds, small tier at the top logit.
        program_regs(16'h8000, 16'h7FFF, 16'h8000, 24'hFFFFFF, 24'hFFFFFF, 24'd0,
                     16'hFFFF, 16'hFFFF);
        push_logit(16'sh7FFF);
        push_close(10'd1023, 10'd0, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        push_logit(16'sh7FFE);
        push_close(10'd0, 10'd1023, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
        push_logit(16'sh7FFF);
        push_close(10'd512, 10'd512, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        wait_idle();

        // Zero gains and a base threshold no logit can beat.
        program_regs(16'h7FFF, 16'h0000, 16'h0000, 24'd0, 24'd0, 24'hFFFFFF, 16'h0000, 16'h0000);
        push_logit(16'sh7FFF);
        push_close(10'd1023, 10'd1023, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        push_logit(16'sd100);
        push_close(10'd1, 10'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        wait_idle();

        repeat (5) begin
            base = int'($urandom_range(0, 768)) - 512;
            sarea = $urandom_range(0, 3000);
            program_regs(16'(base), 16'(base + int'($urandom_range(0, 512))),
                         16'(base + int'($urandom_range(0, 256))), 24'(sarea),
                         24'(sarea + int'($urandom_range(0, 6000))), 24'($urandom_range(0, 400)),
                         16'($urandom_range(128, 1536)), 16'($urandom_range(128, 1536)));
            phase_start = words_queued;
            while (words_queued - phase_start < 85) push_random_cell(1'b0);
            do @(negedge i_clk);
            while (cell_words_pending.size() > 40);
            sender_hold = 1'b1;
            do @(negedge i_clk);
            while (in_valid || boxes_due.size() != 0);
            sender_hold = 1'b0;
            wait_idle();
        end

        // Fully random register contents and words.
        program_regs(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom), 16'($urandom), 16'($urandom));
        phase_start = words_queued;
        while (words_queued - phase_start < 60) push_random_cell(1'b1);
        wait_idle();

        if (box_mismatches == 0 && boxes_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
